### rtl/core/clcd_pkg.sv
// types, codes and the power-up event table shared by the lcd command sequencer
`timescale 1ns / 1ps

package clcd_pkg;

    localparam int CFG_W  = 24;
    localparam int ADDR_W = 2;
    localparam int IDX_W  = 5;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_SHORT  = 2'd0;
    localparam logic [ADDR_W-1:0] REG_MEDIUM = 2'd1;
    localparam logic [ADDR_W-1:0] REG_LONG   = 2'd2;

    localparam logic [CFG_W-1:0] SHORT_RST  = 24'd16;
    localparam logic [CFG_W-1:0] MEDIUM_RST = 24'd160;
    localparam logic [CFG_W-1:0] LONG_RST   = 24'd320;

    // command modes
    localparam logic [1:0] MODE_POWERUP = 2'd0;
    localparam logic [1:0] MODE_INSTR   = 2'd1;
    localparam logic [1:0] MODE_DATA    = 2'd2;
    localparam logic [1:0] MODE_CURSOR  = 2'd3;

    // wait classes
    localparam logic [1:0] W_NONE   = 2'd0;
    localparam logic [1:0] W_SHORT  = 2'd1;
    localparam logic [1:0] W_MEDIUM = 2'd2;
    localparam logic [1:0] W_LONG   = 2'd3;

    localparam logic [7:0] CMD_HOME    = 8'h02;
    localparam logic [3:0] CMD_SET_DDR = 4'h8;
    localparam logic [7:0] POS_MAX     = 8'd15;

    localparam logic [IDX_W-1:0] PWR_LAST_IDX   = 5'd19;
    localparam logic [IDX_W-1:0] BYTE_LAST_IDX  = 5'd1;
    localparam logic [IDX_W-1:0] CUR_SHORT_LAST = 5'd3;
    localparam logic [IDX_W-1:0] CUR_LONG_LAST  = 5'd5;

    localparam logic SEL_INSTR = 1'b0;
    localparam logic SEL_DATA  = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] value;
        logic [7:0] position;
    } item_t;

    typedef struct packed {
        logic [1:0] wait_class;
        logic       strobe_res;
        logic       select;
        logic [3:0] nibble;
        logic       last;
    } result_t;

    // power-up sequence, one event per index; last flag is added by the caller
    function automatic result_t pwr_event(input logic [IDX_W-1:0] idx);
        result_t r;
        r = '0;
        case (idx)
            5'd0:  r = '{W_MEDIUM, 1'b1, SEL_INSTR, 4'h3, 1'b0};
            5'd1:  r = '{W_LONG,   1'b1, SEL_INSTR, 4'h3, 1'b0};
            5'd2:  r = '{W_MEDIUM, 1'b1, SEL_INSTR, 4'h3, 1'b0};
            5'd3:  r = '{W_SHORT,  1'b1, SEL_INSTR, 4'h2, 1'b0};
            5'd4:  r = '{W_SHORT,  1'b0, SEL_INSTR, 4'h0, 1'b0};
            5'd5:  r = '{W_SHORT,  1'b1, SEL_INSTR, 4'h2, 1'b0};
            5'd6:  r = '{W_NONE,   1'b1, SEL_INSTR, 4'h8, 1'b0};
            5'd7:  r = '{W_SHORT,  1'b0, SEL_INSTR, 4'h0, 1'b0};
            5'd8:  r = '{W_SHORT,  1'b1, SEL_INSTR, 4'h0, 1'b0};
            5'd9:  r = '{W_NONE,   1'b1, SEL_INSTR, 4'h8, 1'b0};
            5'd10: r = '{W_MEDIUM, 1'b0, SEL_INSTR, 4'h0, 1'b0};
            5'd11: r = '{W_SHORT,  1'b1, SEL_INSTR, 4'h0, 1'b0};
            5'd12: r = '{W_NONE,   1'b1, SEL_INSTR, 4'hC, 1'b0};
            5'd13: r = '{W_SHORT,  1'b0, SEL_INSTR, 4'h0, 1'b0};
            5'd14: r = '{W_SHORT,  1'b1, SEL_INSTR, 4'h0, 1'b0};
            5'd15: r = '{W_NONE,   1'b1, SEL_INSTR, 4'h6, 1'b0};
            5'd16: r = '{W_MEDIUM, 1'b0, SEL_INSTR, 4'h0, 1'b0};
            5'd17: r = '{W_SHORT,  1'b1, SEL_INSTR, 4'h0, 1'b0};
            5'd18: r = '{W_NONE,   1'b1, SEL_INSTR, 4'h1, 1'b0};
            5'd19: r = '{W_SHORT,  1'b0, SEL_INSTR, 4'h0, 1'b0};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/clcd_event_gen.sv
// combinational decode of one pin event from the held command and event index
`timescale 1ns / 1ps

module clcd_event_gen (
    input  clcd_pkg::item_t                 cmd,
    input  logic [clcd_pkg::IDX_W-1:0]      idx,
    output clcd_pkg::result_t               ev
);
    import clcd_pkg::*;

    logic [7:0] byte_val;
    logic       byte_sel;
    logic       pos_ok;
    logic       is_last;

    assign pos_ok = (cmd.position <= POS_MAX);

    // byte slot is idx[2:1], high nibble on even index
    always_comb
    begin
        byte_val = cmd.value;
        byte_sel = SEL_INSTR;
        case (cmd.mode)
            MODE_INSTR:
            begin
                byte_val = cmd.value;
                byte_sel = SEL_INSTR;
            end
            MODE_DATA:
            begin
                byte_val = cmd.value;
                byte_sel = SEL_DATA;
            end
            MODE_CURSOR:
            begin
                if (idx[2:1] == 2'd0)
                begin
                    byte_val = CMD_HOME;
                    byte_sel = SEL_INSTR;
                end
                else if (idx[2:1] == 2'd1 && pos_ok)
                begin
                    byte_val = {CMD_SET_DDR, cmd.position[3:0]};
                    byte_sel = SEL_INSTR;
                end
                else
                begin
                    byte_val = cmd.value;
                    byte_sel = SEL_DATA;
                end
            end
            default:
            begin
                byte_val = cmd.value;
                byte_sel = SEL_INSTR;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.mode)
            MODE_POWERUP: is_last = (idx == PWR_LAST_IDX);
            MODE_CURSOR:  is_last = (idx == (pos_ok ? CUR_LONG_LAST : CUR_SHORT_LAST));
            default:      is_last = (idx == BYTE_LAST_IDX);
        endcase
    end

    always_comb
    begin
        if (cmd.mode == MODE_POWERUP)
        begin
            ev = pwr_event(idx);
        end
        else
        begin
            ev.wait_class = idx[0] ? W_NONE : W_SHORT;
            ev.strobe_res = 1'b1;
            ev.select     = byte_sel;
            ev.nibble     = idx[0] ? byte_val[3:0] : byte_val[7:4];
            ev.last       = 1'b0;
        end
        ev.last = is_last;
    end

endmodule

### rtl/core/char_lcd_4bit_command_sequencer_top.sv
// top level of the 4-bit character lcd command sequencer
`timescale 1ns / 1ps

// usage
//   command channel: drive item with start high; the beat is taken at a rising
//   edge where start is high and busy is low
//   result channel: each pin event beat shows on result for one cycle with
//   result_strobe high; the receiver cannot stall, so it must take every beat
//   config port: cfg_en writes cfg_wdata into register cfg_addr (0 short,
//   1 medium, 2 long delay); index 3 is dropped; write only while idle
// timing
//   first event passes the held command register and the result register
//   before it shows on result, then one event per cycle: 20 for power-up,
//   2 for a byte, 4 or 6 for a positioned write
//   busy drops in the cycle the last event is decoded, so the next command
//   is taken then and its events follow with no gap
//   throughput is set by the one-event-per-cycle index counter
// reset
//   rst_n clears the sequencer and the result strobe and loads the
//   default delay counts 16, 160 and 320

module char_lcd_4bit_command_sequencer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  clcd_pkg::item_t               item,
    output logic                          result_strobe,
    output clcd_pkg::result_t             result,
    input  logic                          cfg_en,
    input  logic [clcd_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [clcd_pkg::CFG_W-1:0]    cfg_wdata
);
    import clcd_pkg::*;

    // held command and event index
    item_t              cmd_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic               active_reg;
    logic               active_next;

    // result register
    result_t            res_reg;
    logic               res_valid_reg;

    // delay counts, held for the timing back end
    logic [CFG_W-1:0]   short_delay_reg;
    logic [CFG_W-1:0]   medium_delay_reg;
    logic [CFG_W-1:0]   long_delay_reg;

    result_t            ev;
    logic               accept;

    clcd_event_gen u_gen (
        .cmd (cmd_reg),
        .idx (idx_reg),
        .ev  (ev)
    );

    // free again once the final event of the held command is decoded
    assign busy   = active_reg && !ev.last;
    assign accept = start && !busy;

    always_comb
    begin
        idx_next    = idx_reg;
        active_next = active_reg;
        if (accept)
        begin
            idx_next    = '0;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            idx_next = idx_reg + 1'b1;
            // stay active until the final event has been decoded
            if (ev.last)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            res_valid_reg <= active_reg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= item;
        end
        res_reg <= ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_delay_reg  <= SHORT_RST;
            medium_delay_reg <= MEDIUM_RST;
            long_delay_reg   <= LONG_RST;
        end
        else if (cfg_en)
        begin
            case (cfg_addr)
                REG_SHORT:  short_delay_reg  <= cfg_wdata;
                REG_MEDIUM: medium_delay_reg <= cfg_wdata;
                REG_LONG:   long_delay_reg   <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    assign result_strobe = res_valid_reg;
    assign result        = res_reg;

    // a taken command shows its first event after the held command and result registers
    a_first_event: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 result_strobe)
        else $error("no event two cycles after command beat");

    // events of one command come without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last |=> result_strobe)
        else $error("gap inside a command's event list");

    // wait-only events carry no nibble and instruction select
    a_wait_only: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.strobe_res |-> result.nibble == 4'h0 && !result.select)
        else $error("wait-only event with nibble or select set");

    // idle sequencer never reports busy
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> !busy)
        else $error("busy while idle");

endmodule
